// ===== rtl/apbt_pkg.sv =====
// Shared types and constants for the affine point and bounds transform unit.
package apbt_pkg;

  localparam int DEF_FRAC_BITS = 16;
  localparam int COORD_W       = 32;
  localparam int NUM_CORNERS   = 4;
  localparam int CFG_IDX_W     = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    KIND_POINT       = 2'd0,
    KIND_DELTA_POINT = 2'd1,
    KIND_RECT        = 2'd2,
    KIND_DELTA_RECT  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_XX  = 3'd0,
    REG_COEF_YX  = 3'd1,
    REG_COEF_XY  = 3'd2,
    REG_COEF_YY  = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5
  } cfg_reg_t;

endpackage

// ===== rtl/apbt_bound4.sv =====
// Minimum and maximum of four signed coordinates through a two-level compare tree.
module apbt_bound4
  import apbt_pkg::*;
(
  input  coord_t vals [NUM_CORNERS],
  output coord_t lo,
  output coord_t hi
);

  coord_t lo_a, lo_b, hi_a, hi_b;

  always_comb begin
    lo_a = (vals[1] < vals[0]) ? vals[1] : vals[0];
    hi_a = (vals[1] > vals[0]) ? vals[1] : vals[0];
    lo_b = (vals[3] < vals[2]) ? vals[3] : vals[2];
    hi_b = (vals[3] > vals[2]) ? vals[3] : vals[2];
    lo   = (lo_b < lo_a) ? lo_b : lo_a;
    hi   = (hi_b > hi_a) ? hi_b : hi_a;
  end

endmodule

// ===== rtl/affine_point_bounds_transform_unit.sv =====
// Top level of the affine point and bounds transform unit.
// Applies a 2x3 fixed-point affine matrix to one point or one rectangle per beat.
// A point becomes x' = x*coef_xx + y*coef_xy + offset_x and
// y' = x*coef_yx + y*coef_yy + offset_y; the delta kinds leave out the offsets.
// A rectangle has its four corners mapped and the result is their bounding
// box, left/top in out x0/y0 and right/bottom in out x1/y1 (zero for points).
// Numbers are two's complement with FRAC_BITS fraction bits; each product is
// truncated toward minus infinity, the three terms are summed exactly, and a
// coordinate beyond 32 bits is clamped and raises the saturated flag in tuser.
// Throughput is one beat per clock while out_tready is high. After a beat is accepted
// it passes through the input register, the register of the eight
// products, the register of the saturated corner sums and the result register;
// these form four stages, set by the 32x32 multipliers and the wide sums that follow
// them. Each stage holds its beat while the next is full, so a stalled output
// backs up into in_tready only when all stages are occupied. The matrix is
// written through the cfg port, which is always ready; indexes beyond the six
// registers are ignored. Write the matrix only while no beat is in flight.
module affine_point_bounds_transform_unit
  import apbt_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  // Input stream.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [127:0]         in_tdata,  // in_x0, in_y0, in_x1, in_y1 from bit 0 up
  input  logic [1:0]           in_tuser,  // kind
  input  logic                 in_tlast,  // in_last
  // Result stream.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [127:0]         out_tdata, // out_x0, out_y0, out_x1, out_y1 from bit 0 up
  output logic                 out_tuser, // saturated
  output logic                 out_tlast  // out_last
);

  // Width of a product after its fraction bits are dropped, and of a sum of three terms.
  localparam int PW = 2 * COORD_W - FRAC_BITS;
  localparam int SW = PW + 2;
  localparam coord_t ONE_FIXED = coord_t'(64'sd1 <<< FRAC_BITS);
  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;

  // ---------------------------------------------------------------------------
  // Matrix registers. The port never stalls.
  // ---------------------------------------------------------------------------
  coord_t coef_xx_r, coef_yx_r, coef_xy_r, coef_yy_r, offset_x_r, offset_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_xx_r  <= ONE_FIXED;
      coef_yx_r  <= '0;
      coef_xy_r  <= '0;
      coef_yy_r  <= ONE_FIXED;
      offset_x_r <= '0;
      offset_y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COEF_XX:  coef_xx_r  <= coord_t'(cfg_data);
        REG_COEF_YX:  coef_yx_r  <= coord_t'(cfg_data);
        REG_COEF_XY:  coef_xy_r  <= coord_t'(cfg_data);
        REG_COEF_YY:  coef_yy_r  <= coord_t'(cfg_data);
        REG_OFFSET_X: offset_x_r <= coord_t'(cfg_data);
        REG_OFFSET_Y: offset_y_r <= coord_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage handshake. Each stage loads whenever it is empty or its content
  // moves on in the same cycle.
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic en1, en2, en3, en4;

  assign en4       = !s4_v_r || out_tready;
  assign en3       = !s3_v_r || en4;
  assign en2       = !s2_v_r || en3;
  assign en1       = !s1_v_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= in_tvalid;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
      if (en4) s4_v_r <= s3_v_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register.
  // ---------------------------------------------------------------------------
  kind_t  s1_kind_r;
  coord_t s1_x0_r, s1_y0_r, s1_x1_r, s1_y1_r;
  logic   s1_last_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_kind_r <= kind_t'(in_tuser);
      s1_x0_r   <= coord_t'(in_tdata[31:0]);
      s1_y0_r   <= coord_t'(in_tdata[63:32]);
      s1_x1_r   <= coord_t'(in_tdata[95:64]);
      s1_y1_r   <= coord_t'(in_tdata[127:96]);
      s1_last_r <= in_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the eight products, floored by dropping the fraction bits.
  // Index 0 uses x0 or y0, index 1 uses x1 or y1.
  // ---------------------------------------------------------------------------
  logic signed [2*COORD_W-1:0] m_xx [2], m_yx [2], m_xy [2], m_yy [2];
  prod_t  s2_pxx_r [2], s2_pyx_r [2], s2_pxy_r [2], s2_pyy_r [2];
  kind_t  s2_kind_r;
  logic   s2_last_r;

  always_comb begin
    m_xx[0] = s1_x0_r * coef_xx_r;
    m_xx[1] = s1_x1_r * coef_xx_r;
    m_yx[0] = s1_x0_r * coef_yx_r;
    m_yx[1] = s1_x1_r * coef_yx_r;
    m_xy[0] = s1_y0_r * coef_xy_r;
    m_xy[1] = s1_y1_r * coef_xy_r;
    m_yy[0] = s1_y0_r * coef_yy_r;
    m_yy[1] = s1_y1_r * coef_yy_r;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < 2; i++) begin
        s2_pxx_r[i] <= prod_t'(m_xx[i][2*COORD_W-1:FRAC_BITS]);
        s2_pyx_r[i] <= prod_t'(m_yx[i][2*COORD_W-1:FRAC_BITS]);
        s2_pxy_r[i] <= prod_t'(m_xy[i][2*COORD_W-1:FRAC_BITS]);
        s2_pyy_r[i] <= prod_t'(m_yy[i][2*COORD_W-1:FRAC_BITS]);
      end
      s2_kind_r <= s1_kind_r;
      s2_last_r <= s1_last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: corner sums with saturation. Corner bit 0 selects the right
  // edge, bit 1 the bottom edge.
  // ---------------------------------------------------------------------------
  logic   delta;
  coord_t off_x, off_y;
  sum_t   sum_x [NUM_CORNERS], sum_y [NUM_CORNERS];
  logic   ovf_x [NUM_CORNERS], ovf_y [NUM_CORNERS];
  coord_t cx_nxt [NUM_CORNERS], cy_nxt [NUM_CORNERS];
  coord_t s3_cx_r [NUM_CORNERS], s3_cy_r [NUM_CORNERS];
  logic   s3_sat_r [NUM_CORNERS];
  kind_t  s3_kind_r;
  logic   s3_last_r;

  assign delta = (s2_kind_r == KIND_DELTA_POINT) || (s2_kind_r == KIND_DELTA_RECT);
  assign off_x = delta ? '0 : offset_x_r;
  assign off_y = delta ? '0 : offset_y_r;

  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      sum_x[c] = sum_t'(s2_pxx_r[c % 2]) + sum_t'(s2_pxy_r[c / 2]) + sum_t'(off_x);
      sum_y[c] = sum_t'(s2_pyx_r[c % 2]) + sum_t'(s2_pyy_r[c / 2]) + sum_t'(off_y);
      // The value fits when all bits above the coordinate's sign bit agree with it.
      ovf_x[c] = !((&sum_x[c][SW-1:COORD_W-1]) || !(|sum_x[c][SW-1:COORD_W-1]));
      ovf_y[c] = !((&sum_y[c][SW-1:COORD_W-1]) || !(|sum_y[c][SW-1:COORD_W-1]));
      if (ovf_x[c]) cx_nxt[c] = sum_x[c][SW-1] ? COORD_MIN : COORD_MAX;
      else          cx_nxt[c] = coord_t'(sum_x[c][COORD_W-1:0]);
      if (ovf_y[c]) cy_nxt[c] = sum_y[c][SW-1] ? COORD_MIN : COORD_MAX;
      else          cy_nxt[c] = coord_t'(sum_y[c][COORD_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
        s3_cx_r[c]  <= cx_nxt[c];
        s3_cy_r[c]  <= cy_nxt[c];
        s3_sat_r[c] <= ovf_x[c] || ovf_y[c];
      end
      s3_kind_r <= s2_kind_r;
      s3_last_r <= s2_last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: bounding box for rectangles, corner zero for points.
  // ---------------------------------------------------------------------------
  coord_t bx_lo, bx_hi, by_lo, by_hi;
  logic   rect3;
  coord_t x0_nxt, y0_nxt, x1_nxt, y1_nxt;
  logic   sat_nxt;
  coord_t out_x0_r, out_y0_r, out_x1_r, out_y1_r;
  logic   out_sat_r, out_last_r, out_rect_r;

  apbt_bound4 u_bound_x (
    .vals (s3_cx_r),
    .lo   (bx_lo),
    .hi   (bx_hi)
  );

  apbt_bound4 u_bound_y (
    .vals (s3_cy_r),
    .lo   (by_lo),
    .hi   (by_hi)
  );

  assign rect3 = (s3_kind_r == KIND_RECT) || (s3_kind_r == KIND_DELTA_RECT);

  always_comb begin
    if (rect3) begin
      x0_nxt  = bx_lo;
      y0_nxt  = by_lo;
      x1_nxt  = bx_hi;
      y1_nxt  = by_hi;
      sat_nxt = s3_sat_r[0] || s3_sat_r[1] || s3_sat_r[2] || s3_sat_r[3];
    end else begin
      x0_nxt  = s3_cx_r[0];
      y0_nxt  = s3_cy_r[0];
      x1_nxt  = '0;
      y1_nxt  = '0;
      sat_nxt = s3_sat_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out_x0_r   <= x0_nxt;
      out_y0_r   <= y0_nxt;
      out_x1_r   <= x1_nxt;
      out_y1_r   <= y1_nxt;
      out_sat_r  <= sat_nxt;
      out_last_r <= s3_last_r;
      out_rect_r <= rect3;
    end
  end

  assign out_tvalid = s4_v_r;
  assign out_tdata  = {out_y1_r, out_x1_r, out_y0_r, out_x0_r};
  assign out_tuser  = out_sat_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  // A rectangle result is a proper box: left not right of right, top not below bottom.
  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_rect_r) |-> ((out_x0_r <= out_x1_r) && (out_y0_r <= out_y1_r)))
    else $error("bounding box has min above max");

  // When the sink takes a beat, every stage can move, so the input is ready too.
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled although the output is ready");

  // No result survives a reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");
`endif

endmodule

// ===== tb/sv/affine_result_checker.sv =====
`timescale 1ns / 100ps
// Watches the transform unit's channels, predicts every result and compares it.
module affine_result_checker
  import apbt_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [127:0]         in_tdata,
  input  logic [1:0]           in_tuser,
  input  logic                 in_tlast,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [127:0]         out_tdata,
  input  logic                 out_tuser,
  input  logic                 out_tlast,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    logic   clamped;
    logic   last;
  } bounds_t;

  // Shadow copy of the matrix, updated on every accepted write beat.
  coord_t m_xx, m_yx, m_xy, m_yy, off_x, off_y;

  bounds_t pending_results[$];

  function automatic coord_t clamp_coord(input longint v, inout logic flag);
    if (v > longint'(32'sh7fff_ffff)) begin
      flag = 1'b1;
      return coord_t'(32'h7fff_ffff);
    end
    if (v < -longint'(64'sh8000_0000)) begin
      flag = 1'b1;
      return coord_t'(32'h8000_0000);
    end
    return coord_t'(v);
  endfunction

  // Arithmetic shift of a signed product drops the fraction toward minus infinity.
  function automatic void map_corner(input coord_t x, input coord_t y, input logic delta,
                                     output coord_t ox, output coord_t oy, inout logic flag);
    longint sx, sy;
    sx = ((longint'(x) * longint'(m_xx)) >>> FRAC_BITS)
       + ((longint'(y) * longint'(m_xy)) >>> FRAC_BITS);
    sy = ((longint'(x) * longint'(m_yx)) >>> FRAC_BITS)
       + ((longint'(y) * longint'(m_yy)) >>> FRAC_BITS);
    if (!delta) begin
      sx += longint'(off_x);
      sy += longint'(off_y);
    end
    ox = clamp_coord(sx, flag);
    oy = clamp_coord(sy, flag);
  endfunction

  function automatic bounds_t transform_item(input kind_t kind, input logic [127:0] data,
                                             input logic last);
    coord_t  x0, y0, x1, y1;
    coord_t  cx[4], cy[4];
    logic    delta;
    bounds_t r;
    x0 = data[31:0];
    y0 = data[63:32];
    x1 = data[95:64];
    y1 = data[127:96];
    delta = (kind == KIND_DELTA_POINT) || (kind == KIND_DELTA_RECT);
    r.clamped = 1'b0;
    r.last = last;
    if (kind == KIND_POINT || kind == KIND_DELTA_POINT) begin
      map_corner(x0, y0, delta, r.x0, r.y0, r.clamped);
      r.x1 = '0;
      r.y1 = '0;
    end else begin
      map_corner(x0, y0, delta, cx[0], cy[0], r.clamped);
      map_corner(x1, y0, delta, cx[1], cy[1], r.clamped);
      map_corner(x0, y1, delta, cx[2], cy[2], r.clamped);
      map_corner(x1, y1, delta, cx[3], cy[3], r.clamped);
      r.x0 = cx[0];
      r.x1 = cx[0];
      r.y0 = cy[0];
      r.y1 = cy[0];
      for (int i = 1; i < NUM_CORNERS; i++) begin
        if (cx[i] < r.x0) r.x0 = cx[i];
        if (cx[i] > r.x1) r.x1 = cx[i];
        if (cy[i] < r.y0) r.y0 = cy[i];
        if (cy[i] > r.y1) r.y1 = cy[i];
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string field, input coord_t want, input coord_t got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    bounds_t want;
    if (!rst_n) begin
      m_xx  = coord_t'(1 << FRAC_BITS);
      m_yx  = '0;
      m_xy  = '0;
      m_yy  = coord_t'(1 << FRAC_BITS);
      off_x = '0;
      off_y = '0;
      pending_results.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COEF_XX:  m_xx  = cfg_data;
          REG_COEF_YX:  m_yx  = cfg_data;
          REG_COEF_XY:  m_xy  = cfg_data;
          REG_COEF_YY:  m_yy  = cfg_data;
          REG_OFFSET_X: off_x = cfg_data;
          REG_OFFSET_Y: off_y = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result beat arrived with no result expected");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("out_x0", want.x0, out_tdata[31:0]);
          check_field("out_y0", want.y0, out_tdata[63:32]);
          check_field("out_x1", want.x1, out_tdata[95:64]);
          check_field("out_y1", want.y1, out_tdata[127:96]);
          check_field("saturated", coord_t'(want.clamped), coord_t'(out_tuser));
          check_field("out_last", coord_t'(want.last), coord_t'(out_tlast));
        end
      end
      if (in_tvalid && in_tready)
        pending_results.push_back(transform_item(kind_t'(in_tuser), in_tdata, in_tlast));
      outstanding = pending_results.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the affine point and bounds transform unit: stimulus and verdict.
module tb
  import apbt_pkg::*;
();

  localparam int     CYCLE_LIMIT     = 200000;
  localparam int     FLUSH_CYCLES    = 8;
  localparam int     RANDOM_PHASES   = 8;
  localparam int     ITEMS_PER_PHASE = 75;
  localparam int     CALM_PHASE      = 4;
  localparam int     NUM_REGS        = int'(REG_OFFSET_Y) + 1;
  localparam coord_t Q_ONE           = coord_t'(1 << DEF_FRAC_BITS);
  localparam coord_t Q_HALF          = coord_t'(1 << (DEF_FRAC_BITS - 1));
  localparam coord_t C_MAX           = coord_t'(32'h7fff_ffff);
  localparam coord_t C_MIN           = coord_t'(32'h8000_0000);

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [127:0]         in_tdata;
  logic [1:0]           in_tuser;
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [127:0]         out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 calm;
  int                   mismatches;
  int                   outstanding;
  int                   cycle_count = 0;

  always #5 clk = ~clk;

  affine_point_bounds_transform_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  affine_result_checker result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Coordinates: full-range noise half the time, with extremes and small values mixed in
  // so that both clamped and unclamped results show up under most matrices.
  function automatic coord_t pick_coord();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0:       return C_MAX;
      1:       return C_MIN;
      2, 3, 4: return coord_t'(int'($urandom_range(2097152)) - 1048576);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Matrix entries lean toward modest scales, where saturation is the exception.
  function automatic coord_t pick_coef();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0:          return Q_ONE;
      1:          return -Q_ONE;
      2:          return '0;
      3:          return ($urandom_range(1) != 0) ? C_MAX : C_MIN;
      4, 5, 6, 7: return coord_t'(int'($urandom_range(524288)) - 262144);
      default:    return coord_t'($urandom);
    endcase
  endfunction

  // Holds one write beat until the port takes it; cfg_valid stays high for the next.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coord_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Loads the whole matrix, then pokes the unused indexes, which must change nothing.
  task automatic write_matrix(input coord_t xx, input coord_t yx, input coord_t xy,
                              input coord_t yy, input coord_t ox, input coord_t oy);
    write_reg(REG_COEF_XX, xx);
    write_reg(REG_COEF_YX, yx);
    write_reg(REG_COEF_XY, xy);
    write_reg(REG_COEF_YY, yy);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    for (int i = NUM_REGS; i < (1 << CFG_IDX_W); i++)
      write_reg(i[CFG_IDX_W-1:0], coord_t'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Drops the input valid and waits for the pipe to empty before the matrix changes.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (FLUSH_CYCLES) @(negedge clk);
  endtask

  // Presents one beat after an optional random gap and holds it until accepted.
  task automatic send_beat(input kind_t kind, input coord_t x0, input coord_t y0,
                           input coord_t x1, input coord_t y1, input logic last);
    while (!calm && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {y1, x1, y0, x0};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic random_beat();
    send_beat(kind_t'($urandom_range(3)), pick_coord(), pick_coord(), pick_coord(),
              pick_coord(), logic'($urandom_range(1)));
  endtask

  // The result side stalls at random, except through the calm phase.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= calm || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("affine_point_bounds_transform_unit regression: fail");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    calm      <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_COEF_XX;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= KIND_POINT;
    in_tlast  <= 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset matrix is the identity: extremes pass straight through, the unused
    // rectangle fields of a point are ignored, and a reversed rectangle is still
    // bounded left-to-right and top-to-bottom.
    send_beat(KIND_POINT, C_MAX, C_MIN, '0, '0, 1'b0);
    send_beat(KIND_POINT, C_MIN, C_MAX, C_MAX, C_MIN, 1'b1);
    send_beat(KIND_DELTA_POINT, -Q_HALF, Q_ONE, C_MIN, C_MAX, 1'b0);
    send_beat(KIND_RECT, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, 1'b0);
    send_beat(KIND_RECT, C_MAX, C_MAX, C_MIN, C_MIN, 1'b1);
    send_beat(KIND_DELTA_RECT, C_MIN, Q_HALF, C_MAX, -Q_HALF, 1'b0);

    // Largest positive matrix: overflow clamps in both directions.
    wait_idle();
    write_matrix(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    send_beat(KIND_POINT, C_MAX, C_MAX, '0, '0, 1'b0);
    send_beat(KIND_POINT, C_MIN, C_MIN, '0, '0, 1'b1);
    send_beat(KIND_POINT, '0, '0, '0, '0, 1'b0);
    send_beat(KIND_DELTA_POINT, coord_t'(1), coord_t'(-1), '0, '0, 1'b0);
    send_beat(KIND_RECT, C_MIN, C_MIN, C_MAX, C_MAX, 1'b1);

    // Most negative matrix: min times min is the largest product there is.
    wait_idle();
    write_matrix(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    send_beat(KIND_POINT, C_MIN, C_MIN, '0, '0, 1'b0);
    send_beat(KIND_DELTA_POINT, C_MAX, C_MIN, '0, '0, 1'b0);
    send_beat(KIND_DELTA_RECT, coord_t'(-1), coord_t'(-1), coord_t'(1), coord_t'(1), 1'b1);

    // Half-scale rotation: odd raw inputs expose truncation toward minus infinity.
    wait_idle();
    write_matrix('0, Q_HALF, -Q_HALF, '0, coord_t'(3), coord_t'(-3));
    send_beat(KIND_POINT, coord_t'(-1), coord_t'(1), '0, '0, 1'b0);
    send_beat(KIND_DELTA_POINT, coord_t'(-3), coord_t'(-3), '0, '0, 1'b0);
    send_beat(KIND_RECT, Q_ONE, Q_ONE, -Q_ONE, coord_t'(-7), 1'b1);
    send_beat(KIND_DELTA_RECT, coord_t'(5), -Q_HALF, coord_t'(-5), Q_HALF, 1'b0);

    // Random part: each phase loads a new matrix, the extremes among them.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       write_matrix(Q_ONE, '0, '0, Q_ONE, pick_coord(), pick_coord());
        1:       write_matrix(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        2:       write_matrix(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
        default: write_matrix(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                              pick_coord(), pick_coord());
      endcase
      calm <= (ph == CALM_PHASE);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        random_beat();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("affine_point_bounds_transform_unit regression: pass");
    end else begin
      $display("affine_point_bounds_transform_unit regression: fail");
    end
    $finish;
  end

endmodule
